@@ rtl/hds_pkg.sv @@
// Shared types and constants for the heat diffusion stencil.
`default_nettype none

package hds_pkg;

    // Fixed field widths of the temperature and configuration data.
    localparam int TEMP_BITS       = 24;
    localparam int COEFF_FRAC_BITS = 16;
    localparam int COEFF_BITS      = 15;
    localparam int GRID_W_BITS     = 11;
    localparam int GRID_H_BITS     = 16;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 16;

    // Arithmetic widths: the difference sum, the product and the updated value.
    localparam int SUM_BITS  = TEMP_BITS + 3;
    localparam int PROD_BITS = SUM_BITS + COEFF_BITS + 1;
    localparam int RES_BITS  = SUM_BITS + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_COEFF  = 2'd2;

    // Register values after reset.
    localparam int GRID_W_RESET = 20;
    localparam int GRID_H_RESET = 20;
    localparam int COEFF_RESET  = 7463;

    typedef logic signed [TEMP_BITS-1:0] temp_t;

    localparam temp_t TEMP_MAX = {1'b0, {(TEMP_BITS-1){1'b1}}};
    localparam temp_t TEMP_MIN = {1'b1, {(TEMP_BITS-1){1'b0}}};
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(1) <<< (COEFF_FRAC_BITS - 1);

    // One line buffer entry: the row above and the row two above.
    typedef struct packed {
        temp_t one;
        temp_t two;
    } line_pair_t;

    // Neighbors of the point one row above the incoming sample.
    typedef struct packed {
        temp_t center;
        temp_t above;
        temp_t left;
        temp_t right;
    } nbr_t;

    // One pending stencil update.
    typedef struct packed {
        temp_t u;
        temp_t up;
        temp_t down;
        temp_t left;
        temp_t right;
        logic  has_y;
        logic  has_x;
        logic  last;
        logic  eog;
    } job_t;

    // All updates caused by one sample, compacted from slot zero.
    typedef struct packed {
        job_t [2:0]  job;
        logic [1:0]  count;
    } batch_t;

endpackage

`default_nettype wire

@@ rtl/hds_channels_if.sv @@
// Valid/ready channel interfaces for samples, results and configuration writes.
`default_nettype none

interface hds_sample_if import hds_pkg::*; ();
    logic  valid;
    logic  ready;
    temp_t temperature_in;

    modport source (output valid, output temperature_in, input ready);
    modport sink   (input valid, input temperature_in, output ready);
endinterface

interface hds_result_if import hds_pkg::*; ();
    logic  valid;
    logic  ready;
    temp_t temperature_out;
    logic  last_of_run;
    logic  end_of_grid;

    modport source (output valid, output temperature_out, output last_of_run,
                    output end_of_grid, input ready);
    modport sink   (input valid, input temperature_out, input last_of_run,
                    input end_of_grid, output ready);
endinterface

interface hds_cfg_if import hds_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/heat_diffusion_stencil_top.sv @@
// Top level of the heat diffusion stencil: configuration, raster counters, jobs.
// Latency: a transfer's updates wait in the slot queue and then pass the result register;
// the result stream lags the samples by one grid row.
// Throughput: one sample per cycle while the slot queue can take the sample's batch;
// on the last row a sample's results (up to three) queue for the single update unit.
// Reset clears counters, registers and valid flags; line buffers are not cleared.
`default_nettype none

module heat_diffusion_stencil_top import hds_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    hds_sample_if.sink   samples,
    hds_result_if.source results,
    hds_cfg_if.sink      cfg
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_COL_RESET =
        AW'(((GRID_W_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_W_RESET) - 1);
    localparam logic [GRID_H_BITS-1:0] LAST_ROW_RESET = GRID_H_BITS'(GRID_H_RESET - 1);

    logic [AW-1:0]          last_col_reg;
    logic [GRID_H_BITS-1:0] last_row_reg;
    logic [COEFF_BITS-1:0]  coeff_reg;
    logic [AW-1:0]          col_reg;
    logic [AW-1:0]          col_next;
    logic [GRID_H_BITS-1:0] row_reg;
    logic [GRID_H_BITS-1:0] row_next;
    temp_t                  win_reg [3];

    logic                   cfg_write;
    logic                   cfg_hit;
    logic [GRID_W_BITS-1:0] w_field;
    logic [GRID_H_BITS-1:0] h_field;
    logic [AW-1:0]          last_col_cfg;
    logic [GRID_H_BITS-1:0] last_row_cfg;

    logic   accept;
    logic   stage_ready;
    logic   at_last_col;
    logic   at_last_row;
    logic   pa;
    logic   pb;
    logic   pc;
    job_t   ja;
    job_t   jb;
    job_t   jc;
    batch_t batch;
    nbr_t   nbr;

    assign cfg.ready      = 1'b1;
    assign cfg_write      = cfg.valid && cfg.ready;
    assign cfg_hit        = cfg_write && (cfg.index == REG_GRID_WIDTH ||
                            cfg.index == REG_GRID_HEIGHT || cfg.index == REG_STEP_COEFF);
    assign samples.ready  = stage_ready;
    assign accept         = samples.valid && samples.ready;

    // Clamp the written grid size into its working range, kept as last index.
    assign w_field = cfg.data[GRID_W_BITS-1:0];
    assign h_field = cfg.data[GRID_H_BITS-1:0];

    always_comb
    begin
        if (w_field == '0)
        begin
            last_col_cfg = '0;
        end
        else if (32'(w_field) > MAX_WIDTH)
        begin
            last_col_cfg = AW'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col_cfg = AW'(w_field - GRID_W_BITS'(1));
        end
        last_row_cfg = (h_field == '0) ? '0 : h_field - GRID_H_BITS'(1);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= LAST_COL_RESET;
            last_row_reg <= LAST_ROW_RESET;
            coeff_reg    <= COEFF_BITS'(COEFF_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg.index)
                REG_GRID_WIDTH:  last_col_reg <= last_col_cfg;
                REG_GRID_HEIGHT: last_row_reg <= last_row_cfg;
                REG_STEP_COEFF:  coeff_reg    <= cfg.data[COEFF_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Raster position of the next sample; a write to one of the three registers restarts the grid.
    assign at_last_col = (col_reg == last_col_reg);
    assign at_last_row = (row_reg == last_row_reg);

    always_comb
    begin
        col_next = col_reg + AW'(1);
        row_next = row_reg;
        if (at_last_col)
        begin
            col_next = '0;
            row_next = at_last_row ? '0 : row_reg + GRID_H_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Three newest samples of the last row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
        end
        else if (accept && at_last_row)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= samples.temperature_in;
        end
    end

    hds_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .col    (col_reg),
        .wrap   (at_last_col),
        .sample (samples.temperature_in),
        .nbr    (nbr)
    );

    // Updates caused by this sample: the point one row up, the last-row point
    // one column left, and the bottom-right corner passed through.
    always_comb
    begin
        pa = (row_reg != '0);
        pb = at_last_row && (col_reg != '0);
        pc = at_last_row && at_last_col;

        ja.u     = nbr.center;
        ja.up    = nbr.above;
        ja.down  = samples.temperature_in;
        ja.left  = nbr.left;
        ja.right = nbr.right;
        ja.has_y = (row_reg > GRID_H_BITS'(1));
        ja.has_x = (col_reg != '0) && !at_last_col;
        ja.last  = !pb && !pc;
        ja.eog   = 1'b0;

        jb.u     = win_reg[2];
        jb.up    = '0;
        jb.down  = '0;
        jb.left  = win_reg[1];
        jb.right = samples.temperature_in;
        jb.has_y = 1'b0;
        jb.has_x = (col_reg > AW'(1));
        jb.last  = !pc;
        jb.eog   = 1'b0;

        jc.u     = samples.temperature_in;
        jc.up    = '0;
        jc.down  = '0;
        jc.left  = '0;
        jc.right = '0;
        jc.has_y = 1'b0;
        jc.has_x = 1'b0;
        jc.last  = 1'b1;
        jc.eog   = 1'b1;

        batch.job[0] = pa ? ja : (pb ? jb : jc);
        batch.job[1] = pa ? (pb ? jb : jc) : jc;
        batch.job[2] = jc;
        batch.count  = 2'(pa) + 2'(pb) + 2'(pc);
    end

    hds_result_stage u_result_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .batch   (batch),
        .coeff   (coeff_reg),
        .ready   (stage_ready),
        .results (results)
    );

    // The column counter stays inside the configured row.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (col_reg <= last_col_reg))
        else $error("column counter beyond grid width");

    // The bottom-right sample returns the raster position to the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && at_last_row && at_last_col) |=> (row_reg == '0 && col_reg == '0))
        else $error("grid did not wrap after the bottom-right sample");

endmodule

`default_nettype wire

@@ rtl/hds_line_buffer.sv @@
// Line buffer memory holding the two previous rows, with a read-ahead window.
`default_nettype none

module hds_line_buffer import hds_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [$clog2(MAX_WIDTH)-1:0] col,
    input  logic                         wrap,
    input  temp_t                        sample,
    output nbr_t                         nbr
);

    localparam int AW = $clog2(MAX_WIDTH);

    line_pair_t line_mem [MAX_WIDTH];

    line_pair_t rd_data_reg;
    line_pair_t cur_reg;
    line_pair_t hold_reg;
    line_pair_t first_reg;
    line_pair_t second_reg;
    temp_t      left_reg;
    logic       use_hold_reg;

    line_pair_t wr_pair;
    line_pair_t nxt;
    logic [AW-1:0] rd_addr;

    // The entry written now: new sample above the value it pushes down.
    assign wr_pair.one = sample;
    assign wr_pair.two = cur_reg.one;

    // Entry for the next column: from memory, or from the held row start.
    assign nxt     = use_hold_reg ? hold_reg : rd_data_reg;
    assign rd_addr = col + AW'(2);

    // Memory: write the current column, read two columns ahead.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col] <= wr_pair;
            rd_data_reg   <= line_mem[rd_addr];
        end
    end

    // Window registers move one column per transfer; at a row end they
    // reload from the copies of the first two entries of the row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg <= cur_reg.one;
            if (col == AW'(0))
            begin
                first_reg <= wr_pair;
            end
            if (col == AW'(1))
            begin
                second_reg <= wr_pair;
            end
            if (wrap)
            begin
                cur_reg  <= (col == AW'(0)) ? wr_pair : first_reg;
                hold_reg <= (col == AW'(1)) ? wr_pair : second_reg;
            end
            else
            begin
                cur_reg <= nxt;
            end
        end
    end

    // Selects the held entry for the first column after a row end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_hold_reg <= 1'b0;
        end
        else if (accept)
        begin
            use_hold_reg <= wrap;
        end
    end

    assign nbr.center = cur_reg.one;
    assign nbr.above  = cur_reg.two;
    assign nbr.left   = left_reg;
    assign nbr.right  = nxt.one;

endmodule

`default_nettype wire

@@ rtl/hds_result_stage.sv @@
// Pending update slots, the stencil update arithmetic and the result register.
`default_nettype none

module hds_result_stage import hds_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  batch_t                batch,
    input  logic [COEFF_BITS-1:0] coeff,
    output logic                  ready,
    hds_result_if.source          results
);

    job_t       slot_reg [3];
    logic [1:0] count_reg;

    logic       out_valid_reg;
    temp_t      out_temp_reg;
    logic       out_last_reg;
    logic       out_eog_reg;

    logic       issue;
    job_t       job;

    logic signed [SUM_BITS-1:0]     sum_y;
    logic signed [SUM_BITS-1:0]     sum_x;
    logic signed [SUM_BITS-1:0]     sum;
    logic signed [COEFF_BITS:0]     coeff_s;
    logic signed [PROD_BITS-1:0]    prod;
    logic signed [PROD_BITS-1:0]    rounded;
    logic signed [SUM_BITS-1:0]     delta;
    logic signed [RES_BITS-1:0]     res;
    temp_t                          res_sat;

    // Issue one slot whenever the result register is free or being taken.
    assign issue = (count_reg != 2'd0) && (!out_valid_reg || results.ready);
    assign ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && issue);
    assign job   = slot_reg[0];

    // Slot queue: a new batch replaces the drained queue, else shift down.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg[0] <= batch.job[0];
            slot_reg[1] <= batch.job[1];
            slot_reg[2] <= batch.job[2];
        end
        else if (issue)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= batch.count;
        end
        else if (issue)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // Second differences, scaled by the coefficient with round to nearest.
    always_comb
    begin
        sum_y   = SUM_BITS'(job.up) + SUM_BITS'(job.down) - (SUM_BITS'(job.u) <<< 1);
        sum_x   = SUM_BITS'(job.left) + SUM_BITS'(job.right) - (SUM_BITS'(job.u) <<< 1);
        sum     = (job.has_y ? sum_y : SUM_BITS'(0)) + (job.has_x ? sum_x : SUM_BITS'(0));
        coeff_s = $signed({1'b0, coeff});
        prod    = sum * coeff_s;
        rounded = prod + ROUND_HALF;
        delta   = $signed(rounded[PROD_BITS-1:COEFF_FRAC_BITS]);
        res     = RES_BITS'(job.u) + RES_BITS'(delta);
    end

    // Saturate to the temperature range.
    always_comb
    begin
        if (res[RES_BITS-1:TEMP_BITS-1] == '0 || res[RES_BITS-1:TEMP_BITS-1] == '1)
        begin
            res_sat = res[TEMP_BITS-1:0];
        end
        else if (res[RES_BITS-1])
        begin
            res_sat = TEMP_MIN;
        end
        else
        begin
            res_sat = TEMP_MAX;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            out_temp_reg <= res_sat;
            out_last_reg <= job.last;
            out_eog_reg  <= job.eog;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.temperature_out = out_temp_reg;
    assign results.last_of_run     = out_last_reg;
    assign results.end_of_grid     = out_eog_reg;

    // A batch only lands on a queue that drains in this cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (count_reg == 2'd0 || (count_reg == 2'd1 && issue)))
        else $error("batch loaded over pending updates");

    // An issued update shows up in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> out_valid_reg)
        else $error("issued update lost");

    // The bottom-right result is always the final one of its sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_eog_reg) |-> out_last_reg)
        else $error("end of grid without last of run");

endmodule

`default_nettype wire
